// ===== rtl/core/lrpe_pkg.sv =====
package lrpe_pkg;

  localparam int StateW    = 8;
  localparam int SymW      = 6;
  localparam int RuleW     = 8;
  localparam int LenW      = 5;
  localparam int ActAddrW  = 14;
  localparam int ActDepth  = 16384;
  localparam int RuleDepth = 256;
  localparam int StackDepth = 64;
  localparam int StackPtrW = 7;
  localparam int PendDepth = 16;
  localparam int PendCntW  = 5;
  localparam int StepW     = 6;
  localparam logic [StepW-1:0] StepLimit = 6'd63;

  typedef enum logic [1:0] {
    REQ_ACTION = 2'd0,
    REQ_RULE   = 2'd1,
    REQ_PARSE  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    EV_SHIFT  = 3'd0,
    EV_REDUCE = 3'd1,
    EV_ACCEPT = 3'd2,
    EV_ERROR  = 3'd3,
    EV_FAULT  = 3'd4
  } ev_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_ACT,
    ST_RULE,
    ST_EMIT,
    ST_CLEAR
  } fsm_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [ActAddrW-1:0] table_index;
    logic                entry_end;
    logic                entry_reduce;
    logic [7:0]          entry_target;
    logic [7:0]          rule_slot;
    logic [LenW-1:0]     rule_len_in;
    logic [SymW-1:0]     rule_lhs_in;
    logic [SymW-1:0]     token;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [SymW-1:0]   symbol;
    logic [RuleW-1:0]  rule_number;
    logic [LenW-1:0]   rule_length;
    logic [StateW-1:0] new_state;
    logic              last;
  } out_item_t;

  // Table memory port bundle between controller and table store.
  typedef struct packed {
    logic                act_we;
    logic [ActAddrW-1:0] act_addr;
    logic [9:0]          act_wdata;
    logic                rule_we;
    logic [7:0]          rule_addr;
    logic [10:0]         rule_wdata;
  } tbl_req_t;

endpackage

// ===== rtl/core/lrpe_tables.sv =====
module lrpe_tables import lrpe_pkg::*; (
  input  logic        clk,
  input  tbl_req_t    req,
  output logic [9:0]  act_rdata,
  output logic [10:0] rule_rdata
);

  logic [9:0]  act_mem  [ActDepth];
  logic [10:0] rule_mem [RuleDepth];

  always_ff @(posedge clk) begin
    if (req.act_we) begin
      act_mem[req.act_addr] <= req.act_wdata;
    end
    act_rdata <= act_mem[req.act_addr];
  end

  always_ff @(posedge clk) begin
    if (req.rule_we) begin
      rule_mem[req.rule_addr] <= req.rule_wdata;
    end
    rule_rdata <= rule_mem[req.rule_addr];
  end

endmodule

// ===== rtl/core/lr_parse_engine_core.sv =====
// A table write is accepted directly in ST_IDLE. A parse token passes ST_LOOK, ST_ACT and ST_RULE
// before its first event; each further event repeats stack read, action read, rule read and emit.
// A token that ends in its own shift frees the input on the return to ST_IDLE; accept, error
// and fault first pass ST_CLEAR to restore the stack bottom. Output stalls hold the rule stage.
// rst_n (synchronous, active low) sets num_symbols to 64 and empties both stacks, writing state 0
// to the stack bottom in ST_CLEAR once reset is released; the table memories are not cleared.
module lr_parse_engine_core import lrpe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [6:0] cfg_data
);

  fsm_t state_r, state_nxt;
  logic [6:0] nsym_r;
  logic [StackPtrW-1:0] sp_r, sp_nxt;
  logic [PendCntW-1:0]  pc_r, pc_nxt;
  logic [StepW-1:0]     step_r, step_nxt;
  logic [SymW-1:0]      tok_r;
  logic [SymW-1:0]      look_r, look_nxt;
  logic [9:0]           ent_r, ent_nxt;
  out_item_t            ev_r, ev_nxt;
  logic                 ovalid_r, ovalid_nxt;

  logic [StateW-1:0] stk_mem [StackDepth];
  logic [SymW-1:0]   pend_mem [PendDepth];
  logic [StateW-1:0] stk_rd;
  logic [SymW-1:0]   pend_rd;
  logic [5:0]        stk_raddr;
  logic              stk_we;
  logic [5:0]        stk_waddr;
  logic [StateW-1:0] stk_wdata;
  logic              pend_we;
  logic [3:0]        pend_waddr;
  logic [SymW-1:0]   pend_wdata;

  tbl_req_t    treq;
  logic [9:0]  act_rd;
  logic [10:0] rule_rd;
  logic [13:0] prod;

  lrpe_tables u_tables (
    .clk       (clk),
    .req       (treq),
    .act_rdata (act_rd),
    .rule_rdata(rule_rd)
  );

  // Stack memories; reads are registered.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd <= stk_mem[stk_raddr];
    if (pend_we) begin
      pend_mem[pend_waddr] <= pend_wdata;
    end
    pend_rd <= pend_mem[pc_nxt[3:0] - 4'd1];
  end

  assign cfg_ready = (state_r == ST_IDLE) && !ovalid_r;
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign out_valid = ovalid_r;
  assign out_data  = ev_r;
  assign prod      = 14'(14'(stk_rd) * 14'(nsym_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      nsym_r   <= 7'd64;
      sp_r     <= StackPtrW'(1);
      pc_r     <= '0;
      step_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sp_r     <= sp_nxt;
      pc_r     <= pc_nxt;
      step_r   <= step_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_valid && cfg_ready) begin
        nsym_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok_r <= in_data.token;
    end
    look_r <= look_nxt;
    ent_r  <= ent_nxt;
    ev_r   <= ev_nxt;
  end

  always_comb begin
    logic [LenW-1:0] len;
    logic [SymW-1:0] lhs;
    logic            fin;
    state_nxt  = state_r;
    sp_nxt     = sp_r;
    pc_nxt     = pc_r;
    step_nxt   = step_r;
    ovalid_nxt = ovalid_r && !out_ready;
    look_nxt   = look_r;
    ent_nxt    = ent_r;
    ev_nxt     = ev_r;
    stk_raddr  = 6'(sp_r - 7'd1);
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    pend_we    = 1'b0;
    pend_waddr = pc_r[3:0];
    pend_wdata = '0;
    len        = rule_rd[10:6];
    lhs        = rule_rd[5:0];
    fin        = 1'b0;
    treq       = '0;
    treq.act_addr  = 14'(prod + 14'(look_r));
    treq.rule_addr = ent_r[7:0];
    case (state_r)
      ST_IDLE: begin
        treq.act_addr   = in_data.table_index;
        treq.act_wdata  = {in_data.entry_end, in_data.entry_reduce, in_data.entry_target};
        treq.rule_addr  = in_data.rule_slot;
        treq.rule_wdata = {in_data.rule_len_in, in_data.rule_lhs_in};
        if (in_valid && in_ready) begin
          case (req_e'(in_data.req_type))
            REQ_ACTION: treq.act_we = 1'b1;
            REQ_RULE:   treq.rule_we = 1'b1;
            REQ_PARSE: begin
              step_nxt  = '0;
              state_nxt = ST_LOOK;
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        // Stack top and pending top were read last cycle; the action address follows them.
        look_nxt      = (pc_r != '0) ? pend_rd : tok_r;
        treq.act_addr = 14'(prod + 14'(look_nxt));
        state_nxt     = ST_ACT;
      end
      ST_ACT: begin
        ent_nxt        = act_rd;
        treq.rule_addr = act_rd[7:0];
        state_nxt      = ST_RULE;
      end
      ST_RULE: begin
        // Wait for the output register to free before building the next event.
        treq.rule_addr = ent_r[7:0];
        if (!ovalid_r || out_ready) begin
          ev_nxt = '0;
          if (step_r == StepLimit) begin
            ev_nxt.event_res = EV_FAULT;
            fin = 1'b1;
          end else if (ent_r[8]) begin
            if ((7'(len) >= sp_r) || (!ent_r[9] && pc_r == 5'(PendDepth))) begin
              ev_nxt.event_res = EV_FAULT;
              fin = 1'b1;
            end else if (ent_r[9]) begin
              ev_nxt.event_res   = EV_ACCEPT;
              ev_nxt.symbol      = lhs;
              ev_nxt.rule_number = ent_r[7:0];
              ev_nxt.rule_length = len;
              fin = 1'b1;
            end else begin
              ev_nxt.event_res   = EV_REDUCE;
              ev_nxt.symbol      = lhs;
              ev_nxt.rule_number = ent_r[7:0];
              ev_nxt.rule_length = len;
              sp_nxt     = sp_r - 7'(len);
              pend_we    = 1'b1;
              pend_wdata = lhs;
              pc_nxt     = pc_r + 5'd1;
            end
          end else if (ent_r[9]) begin
            ev_nxt.event_res = EV_ERROR;
            ev_nxt.symbol    = look_r;
            fin = 1'b1;
          end else if (sp_r == 7'(StackDepth)) begin
            ev_nxt.event_res = EV_FAULT;
            fin = 1'b1;
          end else begin
            ev_nxt.event_res = EV_SHIFT;
            ev_nxt.symbol    = look_r;
            ev_nxt.new_state = ent_r[7:0];
            stk_we    = 1'b1;
            stk_waddr = sp_r[5:0];
            stk_wdata = ent_r[7:0];
            sp_nxt    = sp_r + 7'd1;
            if (pc_r != '0) begin
              pc_nxt = pc_r - 5'd1;
            end else begin
              ev_nxt.last = 1'b1;
              state_nxt   = ST_IDLE;
            end
          end
          if (fin) begin
            ev_nxt.last = 1'b1;
            sp_nxt = StackPtrW'(1);
            pc_nxt = '0;
            state_nxt = ST_CLEAR;
          end else if (!ev_nxt.last) begin
            state_nxt = ST_EMIT;
          end
          step_nxt   = step_r + 6'd1;
          ovalid_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        // Issue reads of the updated stack tops.
        stk_raddr = 6'(sp_r - 7'd1);
        state_nxt = ST_LOOK;
      end
      ST_CLEAR: begin
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = '0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    sp_r >= StackPtrW'(1) && sp_r <= 7'(StackDepth))
    else $error("stack count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= 5'(PendDepth))
    else $error("pending count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (sp_r == StackPtrW'(1) && pc_r == '0))
    else $error("stacks not reset after ending event");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ready) |=> $stable(ev_r))
    else $error("pending event changed");

endmodule

// ===== test/testbench.sv =====
module testbench;
  import lrpe_pkg::*;

  localparam int NumSt = 8;     // states used by the random grammars
  localparam int NumSy = 8;     // symbols used by the random grammars
  localparam int NumRu = 8;     // rules used by the random grammars
  localparam int IdleLimit = 5000;
  localparam int HoldCycles = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [6:0] cfg_data;

  lr_parse_engine_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow copy of the engine state.
  logic [9:0] act_mem [ActDepth];
  logic [10:0] rule_mem [RuleDepth];
  logic [7:0] state_stk [StackDepth];
  int stk_cnt;
  logic [5:0] pend_stk [PendDepth];
  int pend_cnt;
  int unsigned row_stride;

  out_item_t expected_events[$];
  int mismatches;
  int tokens_sent;
  int events_seen;
  int faults_seen;
  int accepts_seen;
  bit no_idle;
  bit hold_req;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_parse_stacks();
    stk_cnt = 1;
    pend_cnt = 0;
    state_stk[0] = '0;
  endfunction

  function automatic out_item_t make_event(ev_e res, logic [5:0] sym, logic [7:0] rule,
                                           logic [4:0] len, logic [7:0] st, logic lst);
    out_item_t ev;
    ev.event_res = res;
    ev.symbol = sym;
    ev.rule_number = rule;
    ev.rule_length = len;
    ev.new_state = st;
    ev.last = lst;
    return ev;
  endfunction

  // Runs the action loop for one token and queues every event it causes.
  function automatic void predict_token_events(logic [5:0] tok);
    bit from_pend;
    logic [5:0] look;
    logic [7:0] top;
    int unsigned addr;
    logic [9:0] ent;
    logic [10:0] rent;
    int len;
    for (int n = 0; n < 63; n++) begin
      from_pend = pend_cnt != 0;
      look = from_pend ? pend_stk[pend_cnt - 1] : tok;
      top = state_stk[stk_cnt - 1];
      addr = (top * row_stride + look) % ActDepth;
      ent = act_mem[addr];
      if (ent[8]) begin
        rent = rule_mem[ent[7:0]];
        len = rent[10:6];
        if (len >= stk_cnt || (!ent[9] && pend_cnt >= PendDepth)) begin
          clear_parse_stacks();
          expected_events.push_back(make_event(EV_FAULT, 0, 0, 0, 0, 1));
          return;
        end
        if (ent[9]) begin
          clear_parse_stacks();
          expected_events.push_back(make_event(EV_ACCEPT, rent[5:0], ent[7:0], rent[10:6],
                                               0, 1));
          return;
        end
        stk_cnt -= len;
        pend_stk[pend_cnt] = rent[5:0];
        pend_cnt++;
        expected_events.push_back(make_event(EV_REDUCE, rent[5:0], ent[7:0], rent[10:6],
                                             0, 0));
      end else if (ent[9]) begin
        clear_parse_stacks();
        expected_events.push_back(make_event(EV_ERROR, look, 0, 0, 0, 1));
        return;
      end else begin
        if (stk_cnt >= StackDepth) begin
          clear_parse_stacks();
          expected_events.push_back(make_event(EV_FAULT, 0, 0, 0, 0, 1));
          return;
        end
        state_stk[stk_cnt] = ent[7:0];
        stk_cnt++;
        if (from_pend) begin
          pend_cnt--;
          expected_events.push_back(make_event(EV_SHIFT, look, 0, 0, ent[7:0], 0));
        end else begin
          expected_events.push_back(make_event(EV_SHIFT, look, 0, 0, ent[7:0], 1));
          return;
        end
      end
    end
    clear_parse_stacks();
    expected_events.push_back(make_event(EV_FAULT, 0, 0, 0, 0, 1));
  endfunction

  function automatic void apply_request(in_item_t it);
    case (req_e'(it.req_type))
      REQ_ACTION: begin
        act_mem[it.table_index] = {it.entry_end, it.entry_reduce, it.entry_target};
      end
      REQ_RULE: begin
        rule_mem[it.rule_slot] = {it.rule_len_in, it.rule_lhs_in};
      end
      REQ_PARSE: begin
        tokens_sent++;
        predict_token_events(it.token);
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(in_item_t it);
    int g;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    apply_request(it);
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Unused fields carry random bits so that every input bit toggles.
  function automatic in_item_t noise_item();
    in_item_t it;
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    it = bits[$bits(in_item_t)-1:0];
    return it;
  endfunction

  task automatic write_action(int unsigned idx, bit e, bit r, logic [7:0] tgt);
    in_item_t it;
    it = noise_item();
    it.req_type = REQ_ACTION;
    it.table_index = 14'(idx);
    it.entry_end = e;
    it.entry_reduce = r;
    it.entry_target = tgt;
    send_request(it);
  endtask

  task automatic write_rule(logic [7:0] slot, logic [4:0] len, logic [5:0] lhs);
    in_item_t it;
    it = noise_item();
    it.req_type = REQ_RULE;
    it.rule_slot = slot;
    it.rule_len_in = len;
    it.rule_lhs_in = lhs;
    send_request(it);
  endtask

  task automatic parse_token(logic [5:0] tok);
    in_item_t it;
    it = noise_item();
    it.req_type = REQ_PARSE;
    it.token = tok;
    send_request(it);
  endtask

  task automatic wait_drained();
    while (expected_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_row_stride(logic [6:0] v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    row_stride = v;
  endtask

  task automatic test_directed();
    set_row_stride(7'd64);
    // Endless reduce/shift cycle on token 1 runs into the step limit.
    write_rule(0, 0, 2);
    write_rule(1, 1, 2);
    write_action(0 * 64 + 1, 0, 1, 0);
    write_action(0 * 64 + 2, 0, 0, 1);
    write_action(1 * 64 + 1, 0, 1, 1);
    parse_token(1);
    // An empty rule that reduces on its own left-hand symbol fills the pending stack.
    write_rule(2, 0, 4);
    write_action(0 * 64 + 3, 0, 1, 2);
    write_action(0 * 64 + 4, 0, 1, 2);
    parse_token(3);
    // Shift then accept.
    write_rule(3, 1, 7);
    write_action(0 * 64 + 5, 0, 0, 3);
    write_action(3 * 64 + 6, 1, 1, 3);
    parse_token(5);
    parse_token(6);
    // Syntax error.
    write_action(0 * 64 + 7, 1, 0, 8'hA5);
    parse_token(7);
    // Top address and top rule slot; the long rule underflows the stack.
    write_rule(255, 16, 63);
    write_action(0 * 64 + 63, 0, 0, 255);
    write_action(16383, 0, 1, 255);
    parse_token(63);
    parse_token(63);
    begin
      in_item_t it;
      it = noise_item();
      it.req_type = REQ_NONE;
      send_request(it);
    end
  endtask

  task automatic test_stack_overflow();
    write_action(0 * 64 + 8, 0, 0, 0);
    for (int i = 0; i < 64; i++) parse_token(8);
  endtask

  task automatic load_random_grammar();
    int k;
    for (int r = 0; r < NumRu; r++)
      write_rule(8'(r),
                 5'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(0, 16)),
                 6'($urandom_range(0, NumSy - 1)));
    for (int s = 0; s < NumSt; s++)
      for (int y = 0; y < NumSy; y++) begin
        k = $urandom_range(0, 99);
        if (k < 55)
          write_action(s * row_stride + y, 0, 0, 8'($urandom_range(0, NumSt - 1)));
        else if (k < 85)
          write_action(s * row_stride + y, 0, 1, 8'($urandom_range(0, NumRu - 1)));
        else if (k < 93)
          write_action(s * row_stride + y, 1, 1, 8'($urandom_range(0, NumRu - 1)));
        else write_action(s * row_stride + y, 1, 0, 8'($urandom));
      end
  endtask

  task automatic test_random_phase(logic [6:0] stride, int n_tokens, bit with_hold);
    int k;
    in_item_t it;
    set_row_stride(stride);
    load_random_grammar();
    for (int i = 0; i < n_tokens; i++) begin
      if (with_hold && i == n_tokens / 3) hold_req = 1'b1;
      no_idle = (i % 40) >= 30;
      k = $urandom_range(0, 99);
      if (k < 90) begin
        parse_token(6'($urandom_range(0, NumSy - 1)));
      end else if (k < 94) begin
        // Writes outside the area the grammar reads.
        write_rule(8'($urandom_range(NumRu, 255)), 5'($urandom_range(0, 16)), 6'($urandom));
      end else if (k < 97) begin
        write_action($urandom_range(8192, 16382), 1'($urandom), 1'($urandom), 8'($urandom));
      end else begin
        it = noise_item();
        it.req_type = REQ_NONE;
        send_request(it);
      end
    end
    no_idle = 1'b0;
  endtask

  // Result checker.
  always @(posedge clk) begin
    out_item_t exp_ev;
    if (rst_n && out_valid && out_ready) begin
      events_seen++;
      if (out_data.event_res == EV_FAULT) faults_seen++;
      if (out_data.event_res == EV_ACCEPT) accepts_seen++;
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected event %h", out_data);
      end else begin
        exp_ev = expected_events.pop_front();
        if (out_data.event_res !== exp_ev.event_res || out_data.symbol !== exp_ev.symbol ||
            out_data.rule_number !== exp_ev.rule_number ||
            out_data.rule_length !== exp_ev.rule_length ||
            out_data.new_state !== exp_ev.new_state || out_data.last !== exp_ev.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("event mismatch: expected res=%0d sym=%0d rule=%0d len=%0d st=%0d last=%0d",
                     exp_ev.event_res, exp_ev.symbol, exp_ev.rule_number, exp_ev.rule_length,
                     exp_ev.new_state, exp_ev.last);
            $display("                got res=%0d sym=%0d rule=%0d len=%0d st=%0d last=%0d",
                     out_data.event_res, out_data.symbol, out_data.rule_number,
                     out_data.rule_length, out_data.new_state, out_data.last);
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the engine backs up.
  initial begin
    int g;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (g - 1) @(posedge clk);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  initial begin
    int idle_cnt;
    idle_cnt = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cnt = 0;
      else
        idle_cnt++;
      if (idle_cnt >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    tokens_sent = 0;
    events_seen = 0;
    faults_seen = 0;
    accepts_seen = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    row_stride = 64;
    clear_parse_stacks();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_stack_overflow();
    test_random_phase(7'd64, 45, 1'b0);
    test_random_phase(7'd1, 45, 1'b1);
    test_random_phase(7'd127, 45, 1'b0);
    test_random_phase(7'($urandom_range(2, 63)), 45, 1'b0);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d parse tokens producing %0d events (%0d accepts, %0d faults)",
             tokens_sent, events_seen, accepts_seen, faults_seen);
    $display("under row strides 64, 1, 127 and a random one, with one long output stall.");
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d events never seen", mismatches, expected_events.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lrpe_pkg.sv
rtl/core/lrpe_tables.sv
rtl/core/lr_parse_engine_core.sv
test/testbench.sv
